// ===== src/sfmr_pkg.sv =====
// Shared types and constants for the stream first-match replace block.
package sfmr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int SEQ_LEN = MAX_PATTERN + 1;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_e;

  // Configuration as seen by the datapath, lengths already clamped.
  typedef struct packed {
    logic [8*MAX_PATTERN-1:0]     pattern;
    cnt_t                         plen;
    logic [8*MAX_REPLACEMENT-1:0] rep;
    cnt_t                         rlen;
  } cfg_t;

  // Results caused by one item: replacement bytes first, then the leading
  // bytes of the window sequence.
  typedef struct packed {
    logic [8*MAX_REPLACEMENT-1:0] rep;
    cnt_t                         rep_cnt;
    byte_t [SEQ_LEN-1:0]          seq;
    cnt_t                         seq_cnt;
    logic                         last;
    logic                         empty;
  } burst_t;

endpackage

// ===== src/sfmr_cfg.sv =====
// Configuration registers with length clamping.
module sfmr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfmr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output sfmr_pkg::cfg_t                      cfg_o
);
  import sfmr_pkg::*;

  logic [8*MAX_PATTERN-1:0]     pat_q;
  logic [8*MAX_REPLACEMENT-1:0] rep_q;
  cnt_t                         plen_q;
  cnt_t                         rlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_BYTES:      pat_q  <= cfg_data_i[8*MAX_PATTERN-1:0];
        CFG_PATTERN_LENGTH:     plen_q <= cfg_data_i[3:0];
        CFG_REPLACEMENT_BYTES:  rep_q  <= cfg_data_i[8*MAX_REPLACEMENT-1:0];
        CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.pattern = pat_q;
    cfg_o.rep     = rep_q;
    cfg_o.plen    = (plen_q > cnt_t'(MAX_PATTERN)) ? cnt_t'(MAX_PATTERN) : plen_q;
    cfg_o.rlen    = (rlen_q > cnt_t'(MAX_REPLACEMENT)) ? cnt_t'(MAX_REPLACEMENT) : rlen_q;
  end

endmodule

// ===== src/sfmr_edit.sv =====
// Input register, match window state and per-item edit logic.
module sfmr_edit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  sfmr_pkg::byte_t  in_byte_i,
  input  logic             in_last_i,
  input  sfmr_pkg::cfg_t   cfg_i,
  output logic             burst_valid_o,
  input  logic             burst_ready_i,
  output sfmr_pkg::burst_t burst_o
);
  import sfmr_pkg::*;

  logic  iv_q, iv_d;
  byte_t ib_q;
  logic  il_q;

  byte_t [MAX_PATTERN-1:0] win_q, win_d;
  cnt_t                    fill_q, fill_d;
  logic                    done_q, done_d;
  logic                    started_q, started_d;

  byte_t [SEQ_LEN-1:0] seq;
  cnt_t                n;
  cnt_t                e;
  cnt_t                rc;
  logic                ins_start;
  logic                flush_all;
  logic                eq;
  logic                match_now;
  logic [4:0]          src_idx;
  logic                take;
  logic                item_take;

  assign take          = iv_q && burst_ready_i;
  assign item_ready_o  = !iv_q || take;
  assign item_take     = item_valid_i && item_ready_o;
  assign burst_valid_o = iv_q;

  always_comb begin
    iv_d = iv_q;
    if (item_take) begin
      iv_d = 1'b1;
    end else if (take) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      iv_q <= iv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      ib_q <= in_byte_i;
      il_q <= in_last_i;
    end
  end

  // Held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      seq[i] = (fill_q == cnt_t'(i)) ? ib_q : win_q[i];
    end
    seq[SEQ_LEN-1] = ib_q;
  end

  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((cnt_t'(i) < cfg_i.plen) && (seq[i] != cfg_i.pattern[8*i +: 8])) begin
        eq = 1'b0;
      end
    end
  end

  always_comb begin
    n         = fill_q + cnt_t'(1);
    ins_start = !started_q && !done_q && (cfg_i.plen == '0);
    flush_all = ins_start || done_q;
    match_now = !flush_all && (n == cfg_i.plen) && eq;
    rc        = '0;
    e         = '0;
    fill_d    = n;
    priority if (flush_all) begin
      e      = n;
      fill_d = '0;
      if (ins_start) begin
        rc = cfg_i.rlen;
      end
    end else if (n > cfg_i.plen) begin
      e      = n - cfg_i.plen;
      fill_d = cfg_i.plen;
    end else if (n == cfg_i.plen) begin
      if (eq) begin
        rc     = cfg_i.rlen;
        fill_d = '0;
      end else begin
        e      = cnt_t'(1);
        fill_d = n - cnt_t'(1);
      end
    end else begin
      e      = '0;
      fill_d = n;
    end

    done_d    = done_q || ins_start || match_now;
    started_d = 1'b1;
    // Flush everything still held and start the next string clean.
    if (il_q) begin
      e         = match_now ? '0 : n;
      fill_d    = '0;
      done_d    = 1'b0;
      started_d = 1'b0;
    end
  end

  // Keep the bytes that were not emitted, oldest first.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      src_idx  = 5'(i) + 5'(e);
      win_d[i] = (src_idx < 5'(SEQ_LEN)) ? seq[src_idx[3:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      fill_q    <= '0;
      done_q    <= 1'b0;
      started_q <= 1'b0;
    end else if (take) begin
      win_q     <= win_d;
      fill_q    <= fill_d;
      done_q    <= done_d;
      started_q <= started_d;
    end
  end

  always_comb begin
    burst_o.rep     = cfg_i.rep;
    burst_o.rep_cnt = rc;
    burst_o.seq     = seq;
    burst_o.seq_cnt = e;
    burst_o.last    = il_q;
    burst_o.empty   = il_q && (rc == '0) && (e == '0);
  end

endmodule

// ===== src/sfmr_out.sv =====
// Result register that serializes one item's results, one transfer per cycle while res_ready_i is high.
module sfmr_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             burst_valid_i,
  output logic             burst_ready_o,
  input  sfmr_pkg::burst_t burst_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sfmr_pkg::byte_t  out_byte_o,
  output logic             out_valid_o,
  output logic             out_last_o
);
  import sfmr_pkg::*;

  logic [8*MAX_REPLACEMENT-1:0] rep_q;
  cnt_t                         rep_cnt_q;
  byte_t [SEQ_LEN-1:0]          seq_q;
  cnt_t                         seq_cnt_q;
  logic                         last_q;
  logic                         empty_q;

  logic       pending;
  logic       final_ent;
  logic       pop;
  logic       load;
  logic [4:0] left;

  assign left          = 5'(rep_cnt_q) + 5'(seq_cnt_q);
  assign pending       = (left != '0) || empty_q;
  assign final_ent     = empty_q || (left == 5'd1);
  assign pop           = pending && res_ready_i;
  assign burst_ready_o = !pending || (pop && final_ent);
  assign load          = burst_valid_i && burst_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_cnt_q <= '0;
      seq_cnt_q <= '0;
      empty_q   <= 1'b0;
    end else if (load) begin
      rep_cnt_q <= burst_i.rep_cnt;
      seq_cnt_q <= burst_i.seq_cnt;
      empty_q   <= burst_i.empty;
    end else if (pop) begin
      priority if (rep_cnt_q != '0) begin
        rep_cnt_q <= rep_cnt_q - cnt_t'(1);
      end else if (seq_cnt_q != '0) begin
        seq_cnt_q <= seq_cnt_q - cnt_t'(1);
      end else begin
        empty_q <= 1'b0;
      end
    end
  end

  // Advance the byte queues one place per transfer.
  always_ff @(posedge clk_i) begin
    if (load) begin
      rep_q  <= burst_i.rep;
      seq_q  <= burst_i.seq;
      last_q <= burst_i.last;
    end else if (pop) begin
      if (rep_cnt_q != '0) begin
        rep_q <= {8'h00, rep_q[8*MAX_REPLACEMENT-1:8]};
      end else begin
        seq_q <= {8'h00, seq_q[SEQ_LEN-1:1]};
      end
    end
  end

  assign res_valid_o = pending;
  assign out_valid_o = !empty_q;
  assign out_last_o  = last_q && final_ent;
  assign out_byte_o  = empty_q ? 8'h00 : ((rep_cnt_q != '0) ? rep_q[7:0] : seq_q[0]);

endmodule

// ===== src/stream_first_match_replace.sv =====
// Top level of the stream first-match replace block.
//
//   channel   handshake                    payload
//   input     item_valid_i / item_ready_o  in_byte_i, in_last_i
//   result    res_valid_o / res_ready_i    out_byte_o, out_valid_o, out_last_o
//   config    cfg_we_i                     cfg_idx_i, cfg_data_i
//
// An item goes input register -> edit logic -> result register; the result register
// holds an item's results until each is taken, and an item that yields none does not
// occupy it, so one item per cycle is taken while each yields at most one result and
// res_ready_i stays high. Reset clears the configuration, the window and the string
// state.
// Either side may stall at any time; the result register and the input register
// each hold their contents until taken.
module stream_first_match_replace (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            in_last_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            out_valid_o,
  output logic                            out_last_o,
  input  logic                            cfg_we_i,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfmr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfmr_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  sfmr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfmr_edit u_edit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid_i),
    .item_ready_o  (item_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .cfg_i         (cfg),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready),
    .burst_o       (burst)
  );

  sfmr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .burst_i       (burst),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_byte_o    (out_byte_o),
    .out_valid_o   (out_valid_o),
    .out_last_o    (out_last_o)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the stream first-match replace block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfmr_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  valid;
    logic  last;
  } edit_res_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  item_valid_i = 1'b0;
  logic                  item_ready_o;
  logic [7:0]            in_byte_i = 8'h01;
  logic                  in_last_i = 1'b0;
  logic                  res_valid_o;
  logic                  res_ready_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  out_valid_o;
  logic                  out_last_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_PATTERN_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow of the configuration registers and of the edit state.
  logic [63:0]  pat_bytes;
  logic [3:0]   pat_len;
  logic [63:0]  rep_bytes;
  logic [3:0]   rep_len;
  byte_t        win [MAX_PATTERN];
  int unsigned  win_fill;
  bit           replaced;
  bit           started;
  int unsigned  step_cnt;

  edit_res_t    edited_chars[$];
  int unsigned  mismatch_cnt;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_left;

  stream_first_match_replace dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .item_ready_o (item_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .out_last_o   (out_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the edited string
  // ---------------------------------------------------------------------------

  function automatic void emit_char(input byte_t ch, input logic vld);
    edit_res_t r;
    r.data  = ch;
    r.valid = vld;
    r.last  = 1'b0;
    edited_chars.push_back(r);
    step_cnt++;
  endfunction

  function automatic void emit_replacement();
    int unsigned n;
    int unsigned i;
    n = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len;
    for (i = 0; i < n; i++) emit_char(rep_bytes[8*i +: 8], 1'b1);
  endfunction

  function automatic void release_oldest();
    int unsigned i;
    emit_char(win[0], 1'b1);
    for (i = 1; i < MAX_PATTERN; i++) begin
      if (i < win_fill) win[i-1] = win[i];
    end
    win_fill--;
    win[win_fill] = '0;
  endfunction

  function automatic bit window_holds_pattern(input int unsigned plen);
    int unsigned i;
    for (i = 0; i < plen; i++) begin
      if (win[i] != pat_bytes[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_string();
    int unsigned i;
    for (i = 0; i < MAX_PATTERN; i++) win[i] = '0;
    win_fill = 0;
    replaced = 1'b0;
    started  = 1'b0;
  endfunction

  function automatic void substitute_step(input byte_t ch, input logic fin);
    int unsigned plen;
    int unsigned i;
    edit_res_t   tail;
    plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    step_cnt = 0;
    // An empty pattern matches once, ahead of the first character.
    if (!started && !replaced && plen == 0) begin
      emit_replacement();
      replaced = 1'b1;
    end
    started = 1'b1;
    if (replaced) begin
      while (win_fill > 0) release_oldest();
      emit_char(ch, 1'b1);
    end else begin
      if (win_fill >= MAX_PATTERN) release_oldest();
      win[win_fill] = ch;
      win_fill++;
      if (win_fill > plen) begin
        // Pattern got shorter (or empty): drain down, no compare this step.
        while (win_fill > plen) release_oldest();
      end else if (win_fill == plen) begin
        if (window_holds_pattern(plen)) begin
          emit_replacement();
          for (i = 0; i < MAX_PATTERN; i++) win[i] = '0;
          win_fill = 0;
          replaced = 1'b1;
        end else begin
          release_oldest();
        end
      end
    end
    if (fin) begin
      while (win_fill > 0) release_oldest();
      if (step_cnt == 0) emit_char('0, 1'b0);
      tail = edited_chars.pop_back();
      tail.last = 1'b1;
      edited_chars.push_back(tail);
      clear_string();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_ready_i <= 1'b0;
        hold_left--;
      end else begin
        res_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    edit_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && res_ready_i) begin
        if (edited_chars.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result byte=%02h valid=%b last=%b",
                     $realtime, out_byte_o, out_valid_o, out_last_o);
        end else begin
          want = edited_chars.pop_front();
          if (out_byte_o !== want.data || out_valid_o !== want.valid ||
              out_last_o !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch byte/valid/last: expected %02h/%b/%b, got %02h/%b/%b",
                       $realtime, want.data, want.valid, want.last,
                       out_byte_o, out_valid_o, out_last_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  task automatic send_char(input byte_t ch, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    item_valid_i <= 1'b1;
    in_byte_i    <= ch;
    in_last_i    <= fin;
    do @(posedge clk_i); while (!item_ready_o);
    substitute_step(ch, fin);
    @(negedge clk_i);
  endtask

  // Send a string; fin says whether its final character closes it.
  task automatic send_text(input byte_t txt[$], input logic fin = 1'b1);
    int i;
    for (i = 0; i < txt.size(); i++) send_char(txt[i], fin && (i == txt.size() - 1));
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic settle();
    item_valid_i <= 1'b0;
    while (edited_chars.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      CFG_PATTERN_BYTES:      pat_bytes = val;
      CFG_PATTERN_LENGTH:     pat_len   = val[3:0];
      CFG_REPLACEMENT_BYTES:  rep_bytes = val;
      CFG_REPLACEMENT_LENGTH: rep_len   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] pb, input logic [3:0] pl,
                            input logic [63:0] rb, input logic [3:0] rl);
    write_reg(CFG_PATTERN_BYTES, pb);
    write_reg(CFG_PATTERN_LENGTH, {60'd0, pl});
    write_reg(CFG_REPLACEMENT_BYTES, rb);
    write_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rl});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] pack_text(input byte_t txt[$]);
    logic [63:0] v;
    int i;
    v = '0;
    for (i = 0; i < txt.size() && i < 8; i++) v[8*i +: 8] = txt[i];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_pattern();
    settle();
    set_idling(0);
    // Reset config: empty pattern with empty replacement inserts nothing.
    send_text('{8'h01});
    settle();
    set_config(64'd0, 4'd0, pack_text('{8'h5A, 8'h59}), 4'd2);
    send_text('{8'h61, 8'h62});
    send_text('{8'hFF});
  endtask

  task automatic test_first_match();
    settle();
    set_idling(3);
    // Zero byte inside the replacement is emitted like any other.
    set_config(pack_text('{8'h61, 8'h62, 8'h63}), 4'd3,
               pack_text('{8'h00, 8'hFF, 8'h5A}), 4'd3);
    send_text('{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63});
    send_text('{8'h61, 8'h62});
    settle();
    // Whole string replaced by nothing: only an empty end marker is left.
    set_config(pack_text('{8'h61, 8'h62, 8'h63}), 4'd3, 64'd0, 4'd0);
    send_text('{8'h61, 8'h62, 8'h63});
  endtask

  task automatic test_extremes();
    settle();
    set_idling(0);
    set_config(64'h01FF_01FF_01FF_01FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_text('{8'hFF, 8'h01, 8'hFF, 8'h01, 8'hFF, 8'h01, 8'hFF, 8'h01});
    settle();
    // A zero byte in the pattern is not matched here: the input carries 0x42 in its place.
    set_config(pack_text('{8'h41, 8'h00}), 4'd2, pack_text('{8'h51}), 4'd1);
    send_text('{8'h41, 8'h42});
  endtask

  task automatic test_length_clamp();
    settle();
    set_idling(2);
    set_config(64'h0807_0605_0403_0201, 4'd15, 64'h8877_6655_4433_2211, 4'd12);
    send_text('{8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h80});
  endtask

  task automatic test_config_mid_string();
    settle();
    set_idling(0);
    set_config(pack_text('{8'h61, 8'h62, 8'h63, 8'h64}), 4'd4, pack_text('{8'h52}), 4'd1);
    send_text('{8'h61, 8'h62, 8'h63}, 1'b0);
    settle();
    // Shorten the pattern while three characters are held.
    set_config(pack_text('{8'h61, 8'h62, 8'h63, 8'h64}), 4'd2, pack_text('{8'h52}), 4'd1);
    send_text('{8'h78}, 1'b0);
    send_text('{8'h79});
    settle();
    set_config(pack_text('{8'h61, 8'h62, 8'h63, 8'h64}), 4'd4, pack_text('{8'h52}), 4'd1);
    send_text('{8'h61, 8'h62}, 1'b0);
    settle();
    // Empty pattern after the string has started: no insertion, drain held bytes.
    set_config(pack_text('{8'h61, 8'h62, 8'h63, 8'h64}), 4'd0, pack_text('{8'h52}), 4'd1);
    send_text('{8'h63});
  endtask

  // shape: 0 random lengths, 1 full lengths, 2 empty pattern, 3 lengths past the limit
  task automatic run_random_phase(input int mode, input int n_items, input int shape,
                                  input int unsigned hold);
    byte_t       alph [3];
    byte_t       txt[$];
    logic [63:0] pb, rb;
    logic [3:0]  pl, rl;
    int unsigned plen;
    int          sent, i, k;
    bit          paused;
    settle();
    set_idling(mode);
    for (i = 0; i < 3; i++) alph[i] = byte_t'($urandom_range(1, 255));
    for (i = 0; i < 8; i++)
      pb[8*i +: 8] = ($urandom_range(15) == 0) ? 8'h00 : alph[$urandom_range(2)];
    rb = {$urandom, $urandom};
    pl = 4'($urandom_range(0, 8));
    rl = 4'($urandom_range(0, 8));
    case (shape)
      1: begin pl = 4'd8; rl = 4'd8; end
      2: pl = 4'd0;
      3: begin pl = 4'($urandom_range(9, 15)); rl = 4'($urandom_range(9, 15)); end
      default: ;
    endcase
    set_config(pb, pl, rb, rl);
    plen = (pl > MAX_PATTERN) ? MAX_PATTERN : pl;
    hold_left = hold;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      txt.delete();
      if ($urandom_range(3) != 0) begin
        // Pattern embedded among characters drawn mostly from its alphabet.
        k = $urandom_range(0, 5);
        for (i = 0; i < k; i++)
          txt.push_back(($urandom_range(9) < 7) ? alph[$urandom_range(2)]
                                                : byte_t'($urandom_range(1, 255)));
        for (i = 0; i < plen; i++)
          txt.push_back((pb[8*i +: 8] != 0) ? pb[8*i +: 8] : byte_t'($urandom_range(1, 255)));
        k = $urandom_range(0, 5);
        for (i = 0; i < k; i++)
          txt.push_back(($urandom_range(9) < 7) ? alph[$urandom_range(2)]
                                                : byte_t'($urandom_range(1, 255)));
        if (txt.size() == 0) txt.push_back(alph[0]);
      end else begin
        k = $urandom_range(1, 10);
        for (i = 0; i < k; i++) txt.push_back(byte_t'($urandom_range(1, 255)));
      end
      send_text(txt);
      sent += txt.size();
      if (hold > 0 && !paused && sent >= n_items / 2) begin
        // Let the pipeline empty completely before going on.
        paused = 1'b1;
        item_valid_i <= 1'b0;
        while (edited_chars.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  task automatic test_random();
    int ph;
    for (ph = 0; ph < 8; ph++) run_random_phase(ph % 4, 20, (ph < 4) ? ph : 0, 0);
  endtask

  task automatic test_backpressure();
    run_random_phase(0, 60, 0, 300);
    run_random_phase(1, 30, 1, 200);
  endtask

  initial begin
    pat_bytes = '0;
    pat_len   = '0;
    rep_bytes = '0;
    rep_len   = '0;
    clear_string();
    mismatch_cnt = 0;
    hold_left    = 0;
    set_idling(0);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_pattern();
    test_first_match();
    test_extremes();
    test_length_clamp();
    test_config_mid_string();
    test_random();
    test_backpressure();
    settle();

    if (mismatch_cnt == 0 && edited_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sfmr_pkg.sv
src/sfmr_cfg.sv
src/sfmr_edit.sv
src/sfmr_out.sv
src/stream_first_match_replace.sv
test/tb.sv
